@@ design/indexed_pixel_row_packer_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the indexed pixel row packer
// Shared shorthand for clocked implication checks with async reset disable.
// ----------------------------------------------------------------------------
`ifndef INDEXED_PIXEL_ROW_PACKER_CORE_MACROS_SVH
`define INDEXED_PIXEL_ROW_PACKER_CORE_MACROS_SVH

// Same-cycle implication, checked only out of reset
`define IPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ipr: same-cycle check failed");

// Next-cycle implication, checked only out of reset
`define IPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ipr: next-cycle check failed");

`endif

@@ design/ipr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_pkg
// Types and constants shared by the indexed pixel row packer modules.
// ----------------------------------------------------------------------------
package ipr_pkg;

  // Default sizing
  localparam int unsigned MAX_ROW_WIDTH_DEF = 4096;
  localparam int unsigned QUEUE_DEPTH_DEF   = 4;

  // Field and register widths
  localparam int unsigned PIXEL_W     = 8;
  localparam int unsigned ROW_WIDTH_W = 13;
  localparam int unsigned DEPTH_W     = 2;
  localparam int unsigned CFG_DATA_W  = 13;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned PAD_W       = 2;

  // Register reset values
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST = 13'd8;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_WIDTH  = 2'd0,
    CFG_DEPTH_MODE = 2'd1
  } cfg_idx_e;

  // Pixel depth codes (the unused code behaves as 8 bits per pixel)
  typedef enum logic [DEPTH_W-1:0] {
    DEPTH_1BPP = 2'd0,
    DEPTH_4BPP = 2'd1,
    DEPTH_8BPP = 2'd2
  } depth_e;

  // One classified pixel that produces output: a data byte plus padding
  typedef struct packed {
    logic [PIXEL_W-1:0] data;
    logic [PAD_W-1:0]   pad_cnt;
    logic               row_end;
  } job_t;

endpackage

@@ design/indexed_pixel_row_packer_core.sv @@
// Path: an accepted pixel's job is written into the job queue, then loaded into
// the output register, where its first byte becomes valid once the slot is free.
// Throughput: one pixel per cycle while the job queue is not full, one byte per
// cycle while byte_ready_i is high; a row end with padding emits up to four
// bytes, so the queue backs up and intake stalls behind the single output byte.
// Reset: row_width 8, 8 bits per pixel, row state cleared, queue empty.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_pixel_row_packer_core
// Packs 1, 4 or 8 bit palette indices into bytes, padding each row to a
// multiple of four bytes.
// ----------------------------------------------------------------------------
module indexed_pixel_row_packer_core #(
  parameter int unsigned MAX_ROW_WIDTH = ipr_pkg::MAX_ROW_WIDTH_DEF,
  parameter int unsigned QUEUE_DEPTH   = ipr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ipr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           pixel_valid_i,
  output logic                           pixel_ready_o,
  input  logic [ipr_pkg::PIXEL_W-1:0]    pixel_index_i,
  output logic                           byte_valid_o,
  input  logic                           byte_ready_i,
  output logic [ipr_pkg::PIXEL_W-1:0]    packed_byte_o,
  output logic                           row_end_o,
  output logic                           run_last_o
);
  import ipr_pkg::*;

  logic job_push, job_full, job_pop, job_empty;
  job_t push_job, head_job;

  // Intake and classification
  ipr_front #(
    .MAX_ROW_WIDTH(MAX_ROW_WIDTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .pixel_valid_i (pixel_valid_i),
    .pixel_ready_o (pixel_ready_o),
    .pixel_index_i (pixel_index_i),
    .job_full_i    (job_full),
    .job_push_o    (job_push),
    .job_o         (push_job)
  );

  // Decoupling queue
  ipr_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (job_push),
    .push_job_i (push_job),
    .full_o     (job_full),
    .pop_i      (job_pop),
    .head_o     (head_job),
    .empty_o    (job_empty)
  );

  // Byte output and padding
  ipr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (head_job),
    .job_empty_i   (job_empty),
    .job_pop_o     (job_pop),
    .byte_valid_o  (byte_valid_o),
    .byte_ready_i  (byte_ready_i),
    .packed_byte_o (packed_byte_o),
    .row_end_o     (row_end_o),
    .run_last_o    (run_last_o)
  );

endmodule

@@ design/ipr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_front
// Holds configuration and row state, packs pixels into bytes and turns each
// accepted pixel that completes a byte or ends a row into an output job (data byte, padding count, row end).
// ----------------------------------------------------------------------------
module ipr_front #(
  parameter int unsigned MAX_ROW_WIDTH = ipr_pkg::MAX_ROW_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ipr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ipr_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           pixel_valid_i,
  output logic                           pixel_ready_o,
  input  logic [ipr_pkg::PIXEL_W-1:0]    pixel_index_i,
  input  logic                           job_full_i,
  output logic                           job_push_o,
  output ipr_pkg::job_t                  job_o
);
  import ipr_pkg::*;

  localparam int unsigned COL_W = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;

  logic [ROW_WIDTH_W-1:0] row_width_q;
  logic [DEPTH_W-1:0]     depth_mode_q;
  logic [PIXEL_W-1:0]     acc_q, acc_d, acc_new;
  logic [2:0]             pib_q, pib_d;
  logic [COL_W-1:0]       col_q, col_d, last_col;
  logic [PAD_W-1:0]       rbm_q, rbm_d, rbm_inc;
  logic [PIXEL_W-1:0]     mask;
  logic [2:0]             shift;
  logic [3:0]             per_byte, pib_inc;
  logic [31:0]            eff_width;
  logic                   accept, last, emit;

  // Decode pixel depth
  always_comb begin
    unique case (depth_mode_q)
      DEPTH_1BPP: begin
        mask     = 8'h01;
        shift    = pib_q;
        per_byte = 4'd8;
      end
      DEPTH_4BPP: begin
        mask     = 8'h0F;
        shift    = {pib_q[0], 2'b00};
        per_byte = 4'd2;
      end
      default: begin
        mask     = 8'hFF;
        shift    = 3'd0;
        per_byte = 4'd1;
      end
    endcase
  end

  // Clamp row width to 1..MAX_ROW_WIDTH and find the last column
  always_comb begin
    if (row_width_q == '0) begin
      eff_width = 32'd1;
    end else if (32'(row_width_q) > MAX_ROW_WIDTH) begin
      eff_width = MAX_ROW_WIDTH;
    end else begin
      eff_width = 32'(row_width_q);
    end
    last_col = COL_W'(eff_width - 32'd1);
  end

  // Classify the incoming pixel
  assign pixel_ready_o = !job_full_i;
  assign accept        = pixel_valid_i && pixel_ready_o;
  assign acc_new       = acc_q | ((pixel_index_i & mask) << shift);
  assign pib_inc       = {1'b0, pib_q} + 4'd1;
  assign last          = (col_q >= last_col);
  assign emit          = (pib_inc >= per_byte) || last;
  assign rbm_inc       = rbm_q + 2'd1;

  assign job_push_o    = accept && emit;
  assign job_o.data    = acc_new;
  assign job_o.pad_cnt = last ? PAD_W'(2'd0 - rbm_inc) : '0;
  assign job_o.row_end = last;

  // Advance row state
  always_comb begin
    acc_d = acc_q;
    pib_d = pib_q;
    col_d = col_q;
    rbm_d = rbm_q;
    if (accept) begin
      acc_d = emit ? '0 : acc_new;
      pib_d = emit ? 3'd0 : pib_inc[2:0];
      col_d = last ? '0 : col_q + COL_W'(1);
      if (last) begin
        rbm_d = '0;
      end else if (emit) begin
        rbm_d = rbm_inc;
      end
    end
  end

  // Hold configuration; a write to the row width or depth mode register starts a fresh row
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q  <= ROW_WIDTH_RST;
      depth_mode_q <= DEPTH_8BPP;
      acc_q        <= '0;
      pib_q        <= '0;
      col_q        <= '0;
      rbm_q        <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_ROW_WIDTH) begin
        row_width_q <= cfg_data_i[ROW_WIDTH_W-1:0];
        acc_q <= '0;
        pib_q <= '0;
        col_q <= '0;
        rbm_q <= '0;
      end else if (cfg_index_i == CFG_DEPTH_MODE) begin
        depth_mode_q <= cfg_data_i[DEPTH_W-1:0];
        acc_q <= '0;
        pib_q <= '0;
        col_q <= '0;
        rbm_q <= '0;
      end
    end else begin
      acc_q <= acc_d;
      pib_q <= pib_d;
      col_q <= col_d;
      rbm_q <= rbm_d;
    end
  end

endmodule

@@ design/ipr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_queue
// Small job queue that decouples pixel intake from byte output.
// ----------------------------------------------------------------------------
`include "indexed_pixel_row_packer_core_macros.svh"

module ipr_queue #(
  parameter int unsigned DEPTH = ipr_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ipr_pkg::job_t push_job_i,
  output logic          full_o,
  input  logic          pop_i,
  output ipr_pkg::job_t head_o,
  output logic          empty_o
);
  import ipr_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed jobs
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  `IPR_ASSERT_IMP(a_no_push_full, clk_i, rst_ni, push_i, !full_o)
  `IPR_ASSERT_IMP(a_no_pop_empty, clk_i, rst_ni, pop_i, !empty_o)
  `IPR_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= CNT_W'(DEPTH))

endmodule

@@ design/ipr_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipr_back
// Expands queued jobs into output beats: the data byte, then zero padding,
// marking the row end and the final beat of each job.
// ----------------------------------------------------------------------------
`include "indexed_pixel_row_packer_core_macros.svh"

module ipr_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  ipr_pkg::job_t               job_i,
  input  logic                        job_empty_i,
  output logic                        job_pop_o,
  output logic                        byte_valid_o,
  input  logic                        byte_ready_i,
  output logic [ipr_pkg::PIXEL_W-1:0] packed_byte_o,
  output logic                        row_end_o,
  output logic                        run_last_o
);
  import ipr_pkg::*;

  logic               out_valid_q, out_valid_d;
  logic [PIXEL_W-1:0] data_q, data_d;
  logic               row_end_q, row_end_d;
  logic               run_last_q, run_last_d;
  logic [PAD_W-1:0]   pad_left_q, pad_left_d;
  logic               load;

  // Output slot is free when empty or being taken this cycle
  assign load = !out_valid_q || byte_ready_i;

  // Pick the next beat: pending padding first, then a new job
  always_comb begin
    out_valid_d = out_valid_q;
    data_d      = data_q;
    row_end_d   = row_end_q;
    run_last_d  = run_last_q;
    pad_left_d  = pad_left_q;
    job_pop_o   = 1'b0;
    if (load) begin
      if (pad_left_q != '0) begin
        out_valid_d = 1'b1;
        data_d      = '0;
        pad_left_d  = pad_left_q - PAD_W'(1);
        row_end_d   = (pad_left_q == PAD_W'(1));
        run_last_d  = (pad_left_q == PAD_W'(1));
      end else if (!job_empty_i) begin
        job_pop_o   = 1'b1;
        out_valid_d = 1'b1;
        data_d      = job_i.data;
        pad_left_d  = job_i.pad_cnt;
        row_end_d   = job_i.row_end && (job_i.pad_cnt == '0);
        run_last_d  = (job_i.pad_cnt == '0);
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pad_left_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      pad_left_q  <= pad_left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q     <= data_d;
    row_end_q  <= row_end_d;
    run_last_q <= run_last_d;
  end

  assign byte_valid_o  = out_valid_q;
  assign packed_byte_o = data_q;
  assign row_end_o     = row_end_q;
  assign run_last_o    = run_last_q;

  `IPR_ASSERT_IMP(a_pad_needs_valid, clk_i, rst_ni, pad_left_q != '0, out_valid_q)
  `IPR_ASSERT_IMP(a_row_end_is_last, clk_i, rst_ni, out_valid_q && row_end_q, run_last_q)
  `IPR_ASSERT_IMP(a_pop_not_pad, clk_i, rst_ni, job_pop_o, pad_left_q == '0 && load)

endmodule
